>>> rtl/oled_text_glyph_renderer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the OLED text glyph renderer
// Both macros expect signals named clk and rst in the scope of use.
// ----------------------------------------------------------------------------
`ifndef OLED_TEXT_GLYPH_RENDERER_MACROS_SVH
`define OLED_TEXT_GLYPH_RENDERER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OTGR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OTGR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/otgr_pkg.sv
// ----------------------------------------------------------------------------
// OTGR package
// Constants, types and the 5x8 font for the OLED text glyph renderer.
// ----------------------------------------------------------------------------
package otgr_pkg;

  localparam int SEGMENT_COUNT = 128;
  localparam int LAST_PAGE     = 7;
  localparam int GLYPH_WIDTH   = 5;
  localparam int GLYPH_COUNT   = 95;
  localparam int GLYPH_BYTES   = GLYPH_COUNT * GLYPH_WIDTH;
  localparam int ROM_AW        = $clog2(GLYPH_BYTES);
  localparam int PAGE_W        = 3;
  localparam int GSTEP_W       = $clog2(GLYPH_WIDTH + 1);

  localparam logic [7:0] CMD_COLUMN_RANGE = 8'h21;
  localparam logic [7:0] CMD_PAGE_RANGE   = 8'h22;
  localparam logic [7:0] FIRST_GLYPH      = 8'h20;
  localparam logic [7:0] LAST_GLYPH       = 8'h7E;
  localparam logic [7:0] NEWLINE          = 8'h0A;
  localparam logic [7:0] BLANK_COLUMN     = 8'h00;

  localparam logic KIND_CHAR   = 1'b0;
  localparam logic KIND_CURSOR = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CURSOR,
    S_FETCH,
    S_GLYPH
  } state_t;

  typedef enum logic [2:0] {
    CS_COL_CMD,
    CS_COL_START,
    CS_COL_END,
    CS_PAGE_CMD,
    CS_PAGE_START,
    CS_PAGE_END
  } cur_step_t;

  // Font for codes 0x20 to 0x7E, five column bytes per glyph, LSB at the top.
  localparam logic [7:0] GLYPH_ROM [GLYPH_BYTES] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h2f, 8'h00, 8'h00,
    8'h00, 8'h07, 8'h00, 8'h07, 8'h00,
    8'h14, 8'h7f, 8'h14, 8'h7f, 8'h14,
    8'h24, 8'h2a, 8'h7f, 8'h2a, 8'h12,
    8'h23, 8'h13, 8'h08, 8'h64, 8'h62,
    8'h36, 8'h49, 8'h55, 8'h22, 8'h50,
    8'h00, 8'h05, 8'h03, 8'h00, 8'h00,
    8'h00, 8'h1c, 8'h22, 8'h41, 8'h00,
    8'h00, 8'h41, 8'h22, 8'h1c, 8'h00,
    8'h14, 8'h08, 8'h3E, 8'h08, 8'h14,
    8'h08, 8'h08, 8'h3E, 8'h08, 8'h08,
    8'h00, 8'h00, 8'hA0, 8'h60, 8'h00,
    8'h08, 8'h08, 8'h08, 8'h08, 8'h08,
    8'h00, 8'h60, 8'h60, 8'h00, 8'h00,
    8'h20, 8'h10, 8'h08, 8'h04, 8'h02,
    8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E,
    8'h00, 8'h42, 8'h7F, 8'h40, 8'h00,
    8'h42, 8'h61, 8'h51, 8'h49, 8'h46,
    8'h21, 8'h41, 8'h45, 8'h4B, 8'h31,
    8'h18, 8'h14, 8'h12, 8'h7F, 8'h10,
    8'h27, 8'h45, 8'h45, 8'h45, 8'h39,
    8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30,
    8'h01, 8'h71, 8'h09, 8'h05, 8'h03,
    8'h36, 8'h49, 8'h49, 8'h49, 8'h36,
    8'h06, 8'h49, 8'h49, 8'h29, 8'h1E,
    8'h00, 8'h36, 8'h36, 8'h00, 8'h00,
    8'h00, 8'h56, 8'h36, 8'h00, 8'h00,
    8'h08, 8'h14, 8'h22, 8'h41, 8'h00,
    8'h14, 8'h14, 8'h14, 8'h14, 8'h14,
    8'h00, 8'h41, 8'h22, 8'h14, 8'h08,
    8'h02, 8'h01, 8'h51, 8'h09, 8'h06,
    8'h32, 8'h49, 8'h59, 8'h51, 8'h3E,
    8'h7C, 8'h12, 8'h11, 8'h12, 8'h7C,
    8'h7F, 8'h49, 8'h49, 8'h49, 8'h36,
    8'h3E, 8'h41, 8'h41, 8'h41, 8'h22,
    8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C,
    8'h7F, 8'h49, 8'h49, 8'h49, 8'h41,
    8'h7F, 8'h09, 8'h09, 8'h09, 8'h01,
    8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A,
    8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F,
    8'h00, 8'h41, 8'h7F, 8'h41, 8'h00,
    8'h20, 8'h40, 8'h41, 8'h3F, 8'h01,
    8'h7F, 8'h08, 8'h14, 8'h22, 8'h41,
    8'h7F, 8'h40, 8'h40, 8'h40, 8'h40,
    8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F,
    8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F,
    8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E,
    8'h7F, 8'h09, 8'h09, 8'h09, 8'h06,
    8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E,
    8'h7F, 8'h09, 8'h19, 8'h29, 8'h46,
    8'h46, 8'h49, 8'h49, 8'h49, 8'h31,
    8'h01, 8'h01, 8'h7F, 8'h01, 8'h01,
    8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F,
    8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F,
    8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F,
    8'h63, 8'h14, 8'h08, 8'h14, 8'h63,
    8'h07, 8'h08, 8'h70, 8'h08, 8'h07,
    8'h61, 8'h51, 8'h49, 8'h45, 8'h43,
    8'h00, 8'h7F, 8'h41, 8'h41, 8'h00,
    8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55,
    8'h00, 8'h41, 8'h41, 8'h7F, 8'h00,
    8'h04, 8'h02, 8'h01, 8'h02, 8'h04,
    8'h40, 8'h40, 8'h40, 8'h40, 8'h40,
    8'h00, 8'h03, 8'h05, 8'h00, 8'h00,
    8'h20, 8'h54, 8'h54, 8'h54, 8'h78,
    8'h7F, 8'h48, 8'h44, 8'h44, 8'h38,
    8'h38, 8'h44, 8'h44, 8'h44, 8'h20,
    8'h38, 8'h44, 8'h44, 8'h48, 8'h7F,
    8'h38, 8'h54, 8'h54, 8'h54, 8'h18,
    8'h08, 8'h7E, 8'h09, 8'h01, 8'h02,
    8'h18, 8'hA4, 8'hA4, 8'hA4, 8'h7C,
    8'h7F, 8'h08, 8'h04, 8'h04, 8'h78,
    8'h00, 8'h44, 8'h7D, 8'h40, 8'h00,
    8'h40, 8'h80, 8'h84, 8'h7D, 8'h00,
    8'h7F, 8'h10, 8'h28, 8'h44, 8'h00,
    8'h00, 8'h41, 8'h7F, 8'h40, 8'h00,
    8'h7C, 8'h04, 8'h18, 8'h04, 8'h78,
    8'h7C, 8'h08, 8'h04, 8'h04, 8'h78,
    8'h38, 8'h44, 8'h44, 8'h44, 8'h38,
    8'hFC, 8'h24, 8'h24, 8'h24, 8'h18,
    8'h18, 8'h24, 8'h24, 8'h18, 8'hFC,
    8'h7C, 8'h08, 8'h04, 8'h04, 8'h08,
    8'h48, 8'h54, 8'h54, 8'h54, 8'h20,
    8'h04, 8'h3F, 8'h44, 8'h40, 8'h20,
    8'h3C, 8'h40, 8'h40, 8'h20, 8'h7C,
    8'h1C, 8'h20, 8'h40, 8'h20, 8'h1C,
    8'h3C, 8'h40, 8'h30, 8'h40, 8'h3C,
    8'h44, 8'h28, 8'h10, 8'h28, 8'h44,
    8'h1C, 8'hA0, 8'hA0, 8'hA0, 8'h7C,
    8'h44, 8'h64, 8'h54, 8'h4C, 8'h44,
    8'h00, 8'h10, 8'h7C, 8'h82, 8'h00,
    8'h00, 8'h00, 8'hFF, 8'h00, 8'h00,
    8'h00, 8'h82, 8'h7C, 8'h10, 8'h00,
    8'h00, 8'h06, 8'h09, 8'h09, 8'h06
  };

endpackage

>>> rtl/otgr_item_if.sv
// ----------------------------------------------------------------------------
// OTGR input channel
// Carries one character or set-cursor request per transfer.
// ----------------------------------------------------------------------------
interface otgr_item_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_code;
  logic [7:0] line;
  logic [7:0] column;

  modport source (output valid, output kind, output char_code, output line,
                  output column, input ready);
  modport sink (input valid, input kind, input char_code, input line,
                input column, output ready);
endinterface

>>> rtl/otgr_write_if.sv
// ----------------------------------------------------------------------------
// OTGR output channel
// Carries one display controller write per transfer.
// ----------------------------------------------------------------------------
interface otgr_write_if;
  logic       valid;
  logic       ready;
  logic       is_command;
  logic [7:0] value;
  logic       last;

  modport source (output valid, output is_command, output value, output last,
                  input ready);
  modport sink (input valid, input is_command, input value, input last,
                output ready);
endinterface

>>> rtl/oled_text_glyph_renderer.sv
// ----------------------------------------------------------------------------
// OLED text glyph renderer
// Turns characters and set-cursor requests into page-addressed controller
// writes, using a synchronous font ROM and a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Payload                          | Transfer per
//  --------+-----------+----------------------------------+-------------------
//  item    | in        | kind, char_code, line, column    | request
//  wr      | out       | is_command, value, last          | controller write
//
// One request is handled at a time. Once a request is taken, the sequencer
// emits one write per cycle while wr does not stall: six cursor commands for
// a page change or set-cursor request, and six data bytes for a glyph. A
// printable character without a page change first passes through the fetch
// state, which primes the registered font ROM; a newline emits only the cursor
// commands, and an ignored set-cursor request emits no writes at all.
// Stalls on wr hold the sequencer in place;
// the output register lets the next request be taken while the last write of
// the previous one still waits. Reset is synchronous and returns the cursor to
// page 0, column 0; no ROM initialisation pass is needed.
//
`include "oled_text_glyph_renderer_macros.svh"

module oled_text_glyph_renderer (
  input  logic           clk,
  input  logic           rst,
  otgr_item_if.sink      item,
  otgr_write_if.source   wr
);

  localparam logic [otgr_pkg::GSTEP_W-1:0] GSTEP_BLANK =
    otgr_pkg::GSTEP_W'(otgr_pkg::GLYPH_WIDTH);
  localparam logic [otgr_pkg::GSTEP_W-1:0] GSTEP_LAST_ROM =
    otgr_pkg::GSTEP_W'(otgr_pkg::GLYPH_WIDTH - 1);
  localparam logic [8:0] SEG_COUNT_9 = 9'(otgr_pkg::SEGMENT_COUNT);
  localparam logic [7:0] SEG_LAST    = 8'(otgr_pkg::SEGMENT_COUNT - 1);
  localparam logic [otgr_pkg::PAGE_W-1:0] LAST_PAGE_P =
    otgr_pkg::PAGE_W'(otgr_pkg::LAST_PAGE);

  // Sequencer state.
  otgr_pkg::state_t    state, state_next;
  otgr_pkg::cur_step_t cstep;
  logic [otgr_pkg::GSTEP_W-1:0] gstep;
  logic                do_glyph;

  // Cursor state and the column announced by the cursor commands.
  logic [otgr_pkg::PAGE_W-1:0] page;
  logic [7:0]                  column;
  logic [7:0]                  cur_col;

  // Font ROM: address is the glyph base plus the column about to be shown.
  logic [otgr_pkg::ROM_AW-1:0]  glyph_base;
  logic [otgr_pkg::ROM_AW-1:0]  rom_addr;
  logic [7:0]                   rom_data;
  logic [otgr_pkg::GSTEP_W-1:0] rd_step;

  // Output loading.
  logic       load;
  logic       emit;
  logic       emit_cmd;
  logic [7:0] emit_val;
  logic       emit_last;
  logic       accept;

  // Decode of the incoming request.
  logic                        is_newline;
  logic                        printable;
  logic [6:0]                  glyph_idx;
  logic                        wrap;
  logic                        cursor_ok;
  logic [otgr_pkg::PAGE_W-1:0] page_inc;
  logic [7:0]                  col_base;

  assign load   = !wr.valid || wr.ready;
  assign accept = item.valid && item.ready;

  assign is_newline = (item.char_code == otgr_pkg::NEWLINE);
  assign printable  = (item.char_code >= otgr_pkg::FIRST_GLYPH) &&
                      (item.char_code <= otgr_pkg::LAST_GLYPH);
  assign glyph_idx  = printable ? 7'(item.char_code - otgr_pkg::FIRST_GLYPH) : 7'd0;
  // A glyph that would reach the last segment starts on the next page instead.
  assign wrap       = ({1'b0, column} + 9'(otgr_pkg::GLYPH_WIDTH) >= SEG_COUNT_9) ||
                      is_newline;
  assign cursor_ok  = (item.line <= 8'(otgr_pkg::LAST_PAGE)) &&
                      ({1'b0, item.column} < SEG_COUNT_9);
  assign page_inc   = (page == LAST_PAGE_P) ? '0 : page + 1'b1;
  assign col_base   = wrap ? 8'd0 : column;

  // The ROM reads one column ahead while a glyph column is being shown; the
  // read index stops at the last font column since the blank needs no read.
  always_comb begin
    rd_step = gstep;
    if (state == otgr_pkg::S_GLYPH && load && gstep != GSTEP_BLANK) begin
      rd_step = gstep + 1'b1;
    end
    if (rd_step > GSTEP_LAST_ROM) begin
      rd_step = GSTEP_LAST_ROM;
    end
  end

  assign rom_addr = glyph_base + otgr_pkg::ROM_AW'(rd_step);

  always_ff @(posedge clk) begin
    rom_data <= otgr_pkg::GLYPH_ROM[rom_addr];
  end

  // Next state and the write to be loaded this cycle.
  always_comb begin
    state_next = state;
    item.ready = 1'b0;
    emit       = 1'b0;
    emit_cmd   = 1'b0;
    emit_val   = otgr_pkg::BLANK_COLUMN;
    emit_last  = 1'b0;
    unique case (state)
      otgr_pkg::S_IDLE: begin
        item.ready = 1'b1;
        if (item.valid) begin
          if (item.kind == otgr_pkg::KIND_CURSOR) begin
            if (cursor_ok) begin
              state_next = otgr_pkg::S_CURSOR;
            end
          end else if (wrap) begin
            state_next = otgr_pkg::S_CURSOR;
          end else begin
            state_next = otgr_pkg::S_FETCH;
          end
        end
      end
      otgr_pkg::S_CURSOR: begin
        emit     = 1'b1;
        emit_cmd = 1'b1;
        unique case (cstep)
          otgr_pkg::CS_COL_CMD:    emit_val = otgr_pkg::CMD_COLUMN_RANGE;
          otgr_pkg::CS_COL_START:  emit_val = cur_col;
          otgr_pkg::CS_COL_END:    emit_val = SEG_LAST;
          otgr_pkg::CS_PAGE_CMD:   emit_val = otgr_pkg::CMD_PAGE_RANGE;
          otgr_pkg::CS_PAGE_START: emit_val = 8'(page);
          otgr_pkg::CS_PAGE_END:   emit_val = 8'(otgr_pkg::LAST_PAGE);
          default:                 emit_val = otgr_pkg::BLANK_COLUMN;
        endcase
        if (cstep == otgr_pkg::CS_PAGE_END) begin
          emit_last = !do_glyph;
          if (load) begin
            // The ROM has already been reading the first font column.
            state_next = do_glyph ? otgr_pkg::S_GLYPH : otgr_pkg::S_IDLE;
          end
        end
      end
      otgr_pkg::S_FETCH: begin
        state_next = otgr_pkg::S_GLYPH;
      end
      otgr_pkg::S_GLYPH: begin
        emit = 1'b1;
        if (gstep == GSTEP_BLANK) begin
          emit_val  = otgr_pkg::BLANK_COLUMN;
          emit_last = 1'b1;
          if (load) begin
            state_next = otgr_pkg::S_IDLE;
          end
        end else begin
          emit_val = rom_data;
        end
      end
      default: begin
        state_next = otgr_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers and cursor state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= otgr_pkg::S_IDLE;
      wr.valid <= 1'b0;
      page     <= '0;
      column   <= '0;
    end else begin
      state <= state_next;
      if (load) begin
        wr.valid <= emit;
      end
      if (accept) begin
        if (item.kind == otgr_pkg::KIND_CURSOR) begin
          if (cursor_ok) begin
            page   <= item.line[otgr_pkg::PAGE_W-1:0];
            column <= item.column;
          end
        end else begin
          if (wrap) begin
            page <= page_inc;
          end
          // The column advances by the glyph width plus the blank, modulo 256.
          column <= is_newline ? 8'd0 : col_base + 8'(otgr_pkg::GLYPH_WIDTH + 1);
        end
      end
    end
  end

  // Step counters and per-request payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      cstep      <= otgr_pkg::CS_COL_CMD;
      gstep      <= '0;
      do_glyph   <= (item.kind == otgr_pkg::KIND_CHAR) && !is_newline;
      cur_col    <= (item.kind == otgr_pkg::KIND_CURSOR) ? item.column : 8'd0;
      glyph_base <= otgr_pkg::ROM_AW'({glyph_idx, 2'b00}) + otgr_pkg::ROM_AW'(glyph_idx);
    end else if (load) begin
      if (state == otgr_pkg::S_CURSOR && cstep != otgr_pkg::CS_PAGE_END) begin
        cstep <= otgr_pkg::cur_step_t'(cstep + 1'b1);
      end
      if (state == otgr_pkg::S_GLYPH && gstep != GSTEP_BLANK) begin
        gstep <= gstep + 1'b1;
      end
    end
    if (load && emit) begin
      wr.is_command <= emit_cmd;
      wr.value      <= emit_val;
      wr.last       <= emit_last;
    end
  end

  `OTGR_ASSERT_NOW(a_page_in_range, 1'b1, page <= LAST_PAGE_P, "page beyond last page")
  `OTGR_ASSERT_NEXT(a_last_frees_seq, load && emit && emit_last,
                    state == otgr_pkg::S_IDLE, "sequencer busy after final write")
  `OTGR_ASSERT_NEXT(a_glyph_is_data, state == otgr_pkg::S_GLYPH && load,
                    wr.valid && !wr.is_command, "glyph write not marked as data")
  `OTGR_ASSERT_NEXT(a_cursor_opens,
                    state == otgr_pkg::S_CURSOR && load && cstep == otgr_pkg::CS_COL_CMD,
                    wr.is_command && wr.value == otgr_pkg::CMD_COLUMN_RANGE,
                    "cursor sequence opened wrongly")

endmodule
